/* sv/sidta_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sidta_pkg
// Shared types and constants of the signed integer to decimal text block.
// ---------------------------------------------------------------------------
package sidta_pkg;

   localparam logic [5:0] CODE_MINUS = 6'd45;
   localparam logic [5:0] CODE_ZERO  = 6'd48;
   localparam logic [3:0] DABBLE_MIN = 4'd5;
   localparam logic [3:0] DABBLE_ADD = 4'd3;
   localparam logic [3:0] DIGIT_MAX  = 4'd9;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CONV = 5'b00010,
      ST_SIGN = 5'b00100,
      ST_SKIP = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   // Command that every digit cell of the chain sees in a cycle.
   typedef struct packed {
      logic clear;
      logic dabble;
      logic move;
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* sv/sidta_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sidta_if
// Valid/ready channels: integer requests in, ASCII characters out.
// ---------------------------------------------------------------------------
interface sidta_req_if #(parameter int VALUE_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sidta_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

/* sv/sidta_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sidta_cell
// One BCD digit of the conversion chain: clear, shift-and-add-3 step, or a move
// of the lower neighbor's digit when the text is read out.
// ---------------------------------------------------------------------------
module sidta_cell (
   input  wire                     clock,
   input  sidta_pkg::cell_ctrl_type ctrl,
   input  wire                     bit_in,
   input  wire  [3:0]              digit_prev,
   output logic                    bit_out,
   output logic [3:0]              digit
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] adj;

   always_comb begin
      adj = (digit_ff >= sidta_pkg::DABBLE_MIN) ? digit_ff + sidta_pkg::DABBLE_ADD : digit_ff;
      bit_out = adj[3];
      priority if (ctrl.clear) begin
         digit_in = 4'd0;
      end else if (ctrl.dabble) begin
         digit_in = {adj[2:0], bit_in};
      end else if (ctrl.move) begin
         digit_in = digit_prev;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule
`default_nettype wire

/* sv/signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a two's complement integer into its decimal ASCII text, one
// character per transaction, most significant character first.
// ---------------------------------------------------------------------------
//  channel  direction  payload                        meaning
//  req_if   in         value[VALUE_BITS-1:0]          integer to convert
//  rsp_if   out        char_code[5:0], last           one character, last flag
//
//  An integer passes through the accept, VALUE_BITS double-dabble steps, the
//  dropping of leading zeros, the leaving of skipping and the characters.
//  A new request is taken only when the previous text has fully left.
//  A stalled character holds in the chain until it is taken.
//  Reset is synchronous and returns the block to idle.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input wire          clock,
   input wire          reset,
   sidta_req_if.sink   req_if,
   sidta_rsp_if.source rsp_if
);

   localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int CNT_BITS   = $clog2(VALUE_BITS);
   localparam int REM_BITS   = $clog2(NUM_DIGITS + 1);

   sidta_pkg::state_type     state_ff, state_in;
   logic [VALUE_BITS-1:0]    mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [REM_BITS-1:0]      rem_ff, rem_in;
   sidta_pkg::cell_ctrl_type ctrl;

   logic [3:0]          digits [NUM_DIGITS];
   logic [NUM_DIGITS:0] carry;
   logic [3:0]          top_digit;
   logic                req_take;
   logic                rsp_take;
   logic                last_char;

   assign req_take  = req_if.valid && req_if.ready;
   assign rsp_take  = rsp_if.valid && rsp_if.ready;
   assign top_digit = digits[NUM_DIGITS-1];
   assign last_char = (rem_ff == REM_BITS'(1));

   assign carry[0] = mag_ff[VALUE_BITS-1];

   for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_chain
      if (g == 0) begin : g_first
         sidta_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .bit_in     (carry[g]),
            .digit_prev (4'd0),
            .bit_out    (carry[g+1]),
            .digit      (digits[g])
         );
      end else begin : g_rest
         sidta_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .bit_in     (carry[g]),
            .digit_prev (digits[g-1]),
            .bit_out    (carry[g+1]),
            .digit      (digits[g])
         );
      end
   end

   always_comb begin
      state_in    = state_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      ctrl        = '0;
      unique case (state_ff)
         sidta_pkg::ST_IDLE: begin
            if (req_take) begin
               neg_in     = req_if.value[VALUE_BITS-1];
               mag_in     = req_if.value[VALUE_BITS-1] ? VALUE_BITS'(-req_if.value)
                                                       : VALUE_BITS'(req_if.value);
               cnt_in     = CNT_BITS'(VALUE_BITS - 1);
               rem_in     = REM_BITS'(NUM_DIGITS);
               ctrl.clear = 1'b1;
               state_in   = sidta_pkg::ST_CONV;
            end
         end
         sidta_pkg::ST_CONV: begin
            ctrl.dabble = 1'b1;
            mag_in      = {mag_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in      = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) begin
               state_in = neg_ff ? sidta_pkg::ST_SIGN : sidta_pkg::ST_SKIP;
            end
         end
         sidta_pkg::ST_SIGN: begin
            if (rsp_take) begin
               state_in = sidta_pkg::ST_SKIP;
            end
         end
         sidta_pkg::ST_SKIP: begin
            // Leading zeros are shifted away; a lone zero digit is kept.
            if (top_digit == 4'd0 && !last_char) begin
               ctrl.move = 1'b1;
               rem_in    = rem_ff - REM_BITS'(1);
            end else begin
               state_in = sidta_pkg::ST_EMIT;
            end
         end
         sidta_pkg::ST_EMIT: begin
            if (rsp_take) begin
               if (last_char) begin
                  state_in = sidta_pkg::ST_IDLE;
               end else begin
                  ctrl.move = 1'b1;
                  rem_in    = rem_ff - REM_BITS'(1);
               end
            end
         end
         default: begin
            state_in = sidta_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sidta_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
   end

   assign req_if.ready     = (state_ff == sidta_pkg::ST_IDLE);
   assign rsp_if.valid     = (state_ff == sidta_pkg::ST_SIGN) ||
                             (state_ff == sidta_pkg::ST_EMIT);
   assign rsp_if.char_code = (state_ff == sidta_pkg::ST_SIGN) ? sidta_pkg::CODE_MINUS
                             : sidta_pkg::CODE_ZERO + {2'b00, top_digit};
   assign rsp_if.last      = (state_ff == sidta_pkg::ST_EMIT) && last_char;

   // An accepted request always starts the digit chain conversion.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == sidta_pkg::ST_CONV)
      else $error("accepted request did not start conversion");

   // The first digit after zero skipping is nonzero unless it is the only one.
   a_no_leading_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sidta_pkg::ST_EMIT && $past(state_ff) == sidta_pkg::ST_SKIP)
      |-> (top_digit != 4'd0 || last_char))
      else $error("leading zero digit emitted");

   // Digits read out of the chain are valid BCD.
   a_bcd_digit: assert property (@(posedge clock) disable iff (reset)
      state_ff == sidta_pkg::ST_EMIT |-> top_digit <= sidta_pkg::DIGIT_MAX)
      else $error("digit out of BCD range");

   // The final character returns the block to idle.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_if.last) |=> state_ff == sidta_pkg::ST_IDLE)
      else $error("block not idle after final character");

endmodule
`default_nettype wire
